FILE: rtl/rmsd_pkg.sv
// Shared types, constants and helpers for the RGB matrix scan driver.
// No dependencies; used by rgb_matrix_scan_driver.
package rmsd_pkg;

   localparam int PanelWidthDefault = 64;
   localparam int PanelRows         = 32;
   localparam int BankRows          = 16;
   localparam int ScanRows          = 8;

   localparam logic [3:0] MaxPlaneReset = 4'd6;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   // One bit per channel (red, green, blue from bit 0 up), set where the
   // 4-bit channel value is above the current brightness plane.
   function automatic logic [2:0] chan_bits(input logic [11:0] color,
                                            input logic [3:0]  plane);
      logic [2:0] bits;
      bits[0] = color[3:0]  > plane;
      bits[1] = color[7:4]  > plane;
      bits[2] = color[11:8] > plane;
      return bits;
   endfunction

endpackage

FILE: rtl/rmsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable. No dependencies.
module rmsd_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/rgb_matrix_scan_driver.sv
// A tick's shift word is registered in the read stage, then in the response register.
// Throughput: one request per cycle unless stalled; writes and ticks mix freely.
// Each tick reads one pixel from each of two frame banks (rows 0-15, 16-31).
// Reset: counters clear and max_plane returns to 6; the frame banks are then
// zeroed at all 16 * PANEL_WIDTH addresses (1024 by default), taking no requests.
// Depends on rmsd_pkg and rmsd_ram.
module rgb_matrix_scan_driver #(
   parameter int PANEL_WIDTH = rmsd_pkg::PanelWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: max_plane.
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   // Requests.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // pos_x[15:0], pos_y[31:16], color[43:32], zero pad
   input  logic        req_tuser,  // op
   // Shift words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // top_red, top_green, top_blue, bottom_red,
                                   // bottom_green, bottom_blue, zero pad [7:6]
   output logic        rsp_tlast,  // latch
   output logic [6:0]  rsp_tuser   // scan_row[2:0], plane[6:3]
);
   import rmsd_pkg::*;

   localparam int COL_W  = $clog2(PANEL_WIDTH);
   localparam int DEPTH  = BankRows * PANEL_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [COL_W-1:0]  LastCol  = COL_W'(PANEL_WIDTH - 1);
   localparam logic [15:0]       XMax     = 16'(PANEL_WIDTH - 1);
   localparam logic [15:0]       YMax     = 16'(PanelRows - 1);
   localparam logic [ADDR_W-1:0] WidthA   = ADDR_W'(PANEL_WIDTH);
   localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);
   localparam logic [2:0]        LastRow  = 3'(ScanRows - 1);

   // Control state.
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [3:0]        max_plane_ff, max_plane_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              half_ff, half_in;
   logic [2:0]        row_ff, row_in;
   logic [3:0]        plane_ff, plane_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // Payload.
   logic              s1_latch_ff;
   logic [2:0]        s1_row_ff;
   logic [3:0]        s1_plane_ff;
   logic [5:0]        rsp_bits_ff;
   logic              rsp_latch_ff;
   logic [2:0]        rsp_row_ff;
   logic [3:0]        rsp_plane_ff;

   logic signed [15:0] pos_x, pos_y;
   logic [11:0]        color;
   op_type             op;
   logic               accept, wr_accept, tick_accept, s1_adv, last_col;
   logic [COL_W-1:0]   wr_col;
   logic [4:0]         wr_row;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, bank_wr_addr;
   logic               top_wr_en, bot_wr_en;
   logic [11:0]        bank_wr_data, top_pix, bot_pix;

   assign pos_x = req_tdata[15:0];
   assign pos_y = req_tdata[31:16];
   assign color = req_tdata[43:32];
   assign op    = op_type'(req_tuser);

   assign s1_adv      = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !clear_ff && (!s1_valid_ff || s1_adv);
   assign accept      = req_tvalid && req_tready;
   assign wr_accept   = accept && (op == OP_WRITE);
   assign tick_accept = accept && (op == OP_TICK);
   assign last_col    = (col_ff == LastCol);

   // Clamp the write coordinates to the panel edges.
   always_comb begin
      if (pos_x[15]) begin
         wr_col = '0;
      end else if (pos_x > XMax) begin
         wr_col = LastCol;
      end else begin
         wr_col = pos_x[COL_W-1:0];
      end
      if (pos_y[15]) begin
         wr_row = '0;
      end else if (pos_y > YMax) begin
         wr_row = YMax[4:0];
      end else begin
         wr_row = pos_y[4:0];
      end
   end

   // Rows 0-15 live in the top bank and rows 16-31 in the bottom bank. Half 0
   // shows rows r+8 and r+24, half 1 rows r and r+16: the same bank-local row.
   assign wr_addr = ADDR_W'(wr_row[3:0]) * WidthA + ADDR_W'(wr_col);
   assign rd_addr = ADDR_W'({~half_ff, row_ff}) * WidthA + ADDR_W'(col_ff);

   assign bank_wr_addr = clear_ff ? clr_addr_ff : wr_addr;
   assign bank_wr_data = clear_ff ? 12'd0 : color;
   assign top_wr_en    = clear_ff || (wr_accept && !wr_row[4]);
   assign bot_wr_en    = clear_ff || (wr_accept && wr_row[4]);

   rmsd_ram #(.WIDTH(12), .DEPTH(DEPTH)) u_top_bank (
      .clock   (clock),
      .wr_en   (top_wr_en),
      .wr_addr (bank_wr_addr),
      .wr_data (bank_wr_data),
      .rd_en   (tick_accept),
      .rd_addr (rd_addr),
      .rd_data (top_pix)
   );

   rmsd_ram #(.WIDTH(12), .DEPTH(DEPTH)) u_bot_bank (
      .clock   (clock),
      .wr_en   (bot_wr_en),
      .wr_addr (bank_wr_addr),
      .wr_data (bank_wr_data),
      .rd_en   (tick_accept),
      .rd_addr (rd_addr),
      .rd_data (bot_pix)
   );

   always_comb begin
      clear_in     = clear_ff;
      clr_addr_in  = clr_addr_ff;
      max_plane_in = csr_wr_en ? csr_wr_data : max_plane_ff;
      col_in       = col_ff;
      half_in      = half_ff;
      row_in       = row_ff;
      plane_in     = plane_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LastAddr) begin
            clear_in = 1'b0;
         end
      end
      if (tick_accept) begin
         if (!last_col) begin
            col_in = col_ff + 1'b1;
         end else begin
            col_in  = '0;
            half_in = !half_ff;
            if (half_ff) begin
               row_in = row_ff + 1'b1;
               if (row_ff == LastRow) begin
                  // Also wraps when max_plane was lowered below the counter.
                  plane_in = (plane_ff >= max_plane_ff) ? 4'd0 : plane_ff + 1'b1;
               end
            end
         end
      end
      if (tick_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_addr_ff  <= '0;
         max_plane_ff <= MaxPlaneReset;
         col_ff       <= '0;
         half_ff      <= 1'b0;
         row_ff       <= '0;
         plane_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         max_plane_ff <= max_plane_in;
         col_ff       <= col_in;
         half_ff      <= half_in;
         row_ff       <= row_in;
         plane_ff     <= plane_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_accept) begin
         s1_latch_ff <= last_col && half_ff;
         s1_row_ff   <= row_ff;
         s1_plane_ff <= plane_ff;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_bits_ff  <= {chan_bits(bot_pix, s1_plane_ff), chan_bits(top_pix, s1_plane_ff)};
         rsp_latch_ff <= s1_latch_ff;
         rsp_row_ff   <= s1_row_ff;
         rsp_plane_ff <= s1_plane_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_bits_ff};
   assign rsp_tlast  = rsp_latch_ff;
   assign rsp_tuser  = {rsp_plane_ff, rsp_row_ff};

   // The frame banks are busy being zeroed; no request may enter.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("request accepted during frame clear");

   // A tick always reaches the read stage, where its pixel data waits.
   a_tick_to_s1: assert property (@(posedge clock) disable iff (reset)
      tick_accept |=> s1_valid_ff)
      else $error("tick lost before read stage");

   // The plane only moves at the end of a full frame scan, by one or to zero.
   a_plane_step: assert property (@(posedge clock) disable iff (reset)
      (plane_ff != $past(plane_ff)) && !$past(reset) |->
         ($past(tick_accept) && $past(last_col) && $past(half_ff)
          && ($past(row_ff) == LastRow)
          && (plane_ff == 4'd0 || plane_ff == $past(plane_ff) + 4'd1)))
      else $error("plane counter moved out of sequence");

   // The column counter never leaves the panel.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= LastCol)
      else $error("column counter out of range");

   // A latch is only ever presented on the last shift of the second half.
   a_latch_half: assert property (@(posedge clock) disable iff (reset)
      tick_accept && !half_ff |=> !s1_latch_ff)
      else $error("latch raised in first half of a row");

endmodule
